/* sv/fdsrc_pkg.sv */
// Shared constants, types and codes for the drop-oldest sample rate converter.
`timescale 1ns / 1ps

package fdsrc_pkg;

  localparam int QUEUE_DEPTH     = 16384;
  localparam int PHASE_FRAC_BITS = 16;

  localparam int ADDR_W   = $clog2(QUEUE_DEPTH);
  localparam int OCC_W    = ADDR_W + 1;
  localparam int STEP_W   = 19;
  localparam int SAMPLE_W = 17;
  localparam int BYTE_W   = 8;
  localparam int SUM_W    = ((PHASE_FRAC_BITS > STEP_W) ? PHASE_FRAC_BITS : STEP_W) + 1;
  localparam int CONS_W   = SUM_W - PHASE_FRAC_BITS;

  localparam int HALF_DEPTH = QUEUE_DEPTH / 2;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(94124);
  localparam logic [BYTE_W-1:0] SILENCE    = 8'h80;

  // Q15 unity, its negative, and 128*unity + half LSB for the byte rounding.
  localparam logic signed [SAMPLE_W-1:0] ONE_Q15     = SAMPLE_W'(32768);
  localparam logic signed [SAMPLE_W-1:0] NEG_ONE_Q15 = -SAMPLE_W'(32768);
  localparam logic signed [24:0]         BYTE_BIAS   = 25'sd4210688;
  localparam logic signed [24:0]         BYTE_GAIN   = 25'sd127;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_PULL  = 2'd1,
    OP_FLUSH = 2'd2
  } op_e;

  typedef struct packed {
    logic                       we;
    logic [ADDR_W-1:0]          waddr;
    logic signed [SAMPLE_W-1:0] wdata;
    logic                       re;
    logic [ADDR_W-1:0]          raddr;
  } mem_req_t;

  typedef struct packed {
    logic             data_pull;
    logic             underrun;
    logic             overflow;
    logic [OCC_W-1:0] fill;
  } item_meta_t;

endpackage

/* sv/fdsrc_if.sv */
// Valid/ready channel interfaces for the input and result beats.
`timescale 1ns / 1ps

interface fdsrc_in_if import fdsrc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 operation;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink   (input valid, input operation, input sample, output ready);
endinterface

interface fdsrc_out_if import fdsrc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              underrun;
  logic              overflow_dropped;
  logic [OCC_W-1:0]  fill_level;

  modport source (output valid, output out_byte, output underrun,
                  output overflow_dropped, output fill_level, input ready);
  modport sink   (input valid, input out_byte, input underrun,
                  input overflow_dropped, input fill_level, output ready);
endinterface

/* sv/fdsrc_ctrl.sv */
// Queue pointer, occupancy and phase control; issues store accesses per beat.
`timescale 1ns / 1ps

module fdsrc_ctrl import fdsrc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [1:0]                 operation,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       cfg_we,
  input  logic [STEP_W-1:0]          cfg_wdata,
  output mem_req_t                   mem_req,
  output item_meta_t                 meta
);

  logic [ADDR_W-1:0]          head_r, head_nxt;
  logic [OCC_W-1:0]           occ_r, occ_nxt;
  logic [PHASE_FRAC_BITS-1:0] phase_r, phase_nxt;
  logic [STEP_W-1:0]          step_r;

  logic [SUM_W-1:0]  phase_sum;
  logic [CONS_W-1:0] consumed;
  logic              full;
  logic              empty;

  assign full      = (occ_r == OCC_W'(QUEUE_DEPTH));
  assign empty     = (occ_r == '0);
  assign phase_sum = SUM_W'(phase_r) + SUM_W'(step_r);
  assign consumed  = phase_sum[SUM_W-1:PHASE_FRAC_BITS];

  always_comb begin
    head_nxt      = head_r;
    occ_nxt       = occ_r;
    phase_nxt     = phase_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = head_r + occ_r[ADDR_W-1:0];
    mem_req.wdata = sample;
    mem_req.re    = 1'b0;
    mem_req.raddr = head_r;
    meta.data_pull = 1'b0;
    meta.underrun  = 1'b0;
    meta.overflow  = 1'b0;
    case (operation)
      OP_PUSH: begin
        mem_req.we = accept;
        if (full) begin
          // drop oldest so the newest half remain
          head_nxt      = head_r + ADDR_W'(HALF_DEPTH + 1);
          occ_nxt       = OCC_W'(HALF_DEPTH);
          phase_nxt     = '0;
          meta.overflow = 1'b1;
        end else begin
          occ_nxt = occ_r + 1'b1;
        end
      end
      OP_PULL: begin
        if (empty) begin
          meta.underrun = 1'b1;
        end else begin
          mem_req.re     = accept;
          meta.data_pull = 1'b1;
          if (OCC_W'(consumed) >= occ_r) begin
            head_nxt  = '0;
            occ_nxt   = '0;
            phase_nxt = '0;
          end else begin
            head_nxt  = head_r + ADDR_W'(consumed);
            occ_nxt   = occ_r - OCC_W'(consumed);
            phase_nxt = phase_sum[PHASE_FRAC_BITS-1:0];
          end
        end
      end
      OP_FLUSH: begin
        head_nxt  = '0;
        occ_nxt   = '0;
        phase_nxt = '0;
      end
      default: begin
      end
    endcase
    meta.fill = occ_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      occ_r   <= '0;
      phase_r <= '0;
      step_r  <= STEP_RESET;
    end else begin
      if (accept) begin
        head_r  <= head_nxt;
        occ_r   <= occ_nxt;
        phase_r <= phase_nxt;
      end
      if (cfg_we) begin
        step_r <= cfg_wdata;
      end
    end
  end

endmodule

/* sv/fdsrc_store.sv */
// Sample ring memory: one write or one registered read per cycle.
`timescale 1ns / 1ps

module fdsrc_store import fdsrc_pkg::*; (
  input  logic                       clk,
  input  mem_req_t                   mem_req,
  output logic signed [SAMPLE_W-1:0] rd_data
);

  logic signed [SAMPLE_W-1:0] mem [QUEUE_DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rd_data_r <= mem[mem_req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/fdsrc_out.sv */
// Read-data stage, clamp and byte conversion, and the result register.
`timescale 1ns / 1ps

module fdsrc_out import fdsrc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  item_meta_t                 meta,
  input  logic signed [SAMPLE_W-1:0] rd_data,
  output logic                       take_ready,
  fdsrc_out_if.source                out_if
);

  logic       s1_v_r;
  item_meta_t s1_meta_r;
  logic       o_v_r;
  logic [BYTE_W-1:0] o_byte_r;
  logic              o_under_r;
  logic              o_over_r;
  logic [OCC_W-1:0]  o_fill_r;

  logic                       o_free;
  logic                       s1_adv;
  logic signed [SAMPLE_W-1:0] v_cl;
  logic signed [24:0]         num;
  logic [BYTE_W-1:0]          byte_nxt;

  assign o_free     = !o_v_r || out_if.ready;
  assign s1_adv     = s1_v_r && o_free;
  assign take_ready = !s1_v_r || o_free;

  always_comb begin
    if (rd_data > ONE_Q15) begin
      v_cl = ONE_Q15;
    end else if (rd_data < NEG_ONE_Q15) begin
      v_cl = NEG_ONE_Q15;
    end else begin
      v_cl = rd_data;
    end
    num      = BYTE_BIAS + 25'(v_cl) * BYTE_GAIN;
    byte_nxt = s1_meta_r.data_pull ? num[22:15] : SILENCE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (take_ready) begin
        s1_v_r <= accept;
      end
      if (o_free) begin
        o_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta_r <= meta;
    end
    if (s1_adv) begin
      o_byte_r  <= byte_nxt;
      o_under_r <= s1_meta_r.underrun;
      o_over_r  <= s1_meta_r.overflow;
      o_fill_r  <= s1_meta_r.fill;
    end
  end

  assign out_if.valid            = o_v_r;
  assign out_if.out_byte         = o_byte_r;
  assign out_if.underrun         = o_under_r;
  assign out_if.overflow_dropped = o_over_r;
  assign out_if.fill_level       = o_fill_r;

endmodule

/* sv/fifo_drop_sample_rate_converter.sv */
// Top level of the drop-oldest nearest-sample rate converter.
//
// Use:
//   in_if  carries one beat per operation: push a Q2.15 sample, pull one
//          host sample, or flush the queue and phase. Code 3 is a no-op
//          that still returns a result.
//   out_if returns exactly one result beat per input beat, in order:
//          offset-binary byte, underrun and overflow flags, fill level.
//   cfg_we/cfg_wdata write phase_step (16 fraction bits); write it only
//          while no beats are in flight.
// Timing:
//   One beat per cycle sustained while out_if.ready stays high. A result
//   passes through the registered read of the sample memory, then
//   through the conversion into the result register.
// Reset (rst_n low, synchronous): queue empty, read head and phase zero,
//   phase_step back to 94124. Sample memory is not cleared; entries are
//   only ever read after being written. No clearing sweep is needed.
// Stall: with out_if.ready low the result register and the read stage
//   hold; in_if.ready drops once both are full and returns the cycle the
//   receiver takes a beat.
`timescale 1ns / 1ps

module fifo_drop_sample_rate_converter import fdsrc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  fdsrc_in_if.sink          in_if,
  fdsrc_out_if.source       out_if,
  input  logic              cfg_we,
  input  logic [STEP_W-1:0] cfg_wdata
);

  logic                       accept;
  logic                       take_ready;
  mem_req_t                   mem_req;
  item_meta_t                 meta;
  logic signed [SAMPLE_W-1:0] rd_data;

  assign in_if.ready = take_ready;
  assign accept      = in_if.valid && take_ready;

  // pointer/phase bookkeeping is resolved on the accept edge, so the next
  // beat sees up-to-date head and occupancy with no interlock
  fdsrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .operation (in_if.operation),
    .sample    (in_if.sample),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .mem_req   (mem_req),
    .meta      (meta)
  );

  // a push writes on its accept edge; any later pull reads after it,
  // so the same entry never sees a write and a read together
  fdsrc_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  fdsrc_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .meta       (meta),
    .rd_data    (rd_data),
    .take_ready (take_ready),
    .out_if     (out_if)
  );

endmodule

/* sv/fdsrc_chk.sv */
// Port-level checker for the rate converter, bound to the top level.
`timescale 1ns / 1ps

module fdsrc_chk import fdsrc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [BYTE_W-1:0] out_byte,
  input  logic              underrun,
  input  logic              overflow_dropped,
  input  logic [OCC_W-1:0]  fill_level
);

  // stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn under stall");

  // an underrun reports an empty queue and silence
  a_under: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && underrun |-> out_byte == SILENCE && fill_level == '0)
    else $error("underrun beat not silent or not empty");

  // an overflow leaves exactly half the queue
  a_over: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && overflow_dropped |-> fill_level == OCC_W'(HALF_DEPTH) && !underrun)
    else $error("overflow beat with wrong fill");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> fill_level <= OCC_W'(QUEUE_DEPTH))
    else $error("fill level beyond depth");

endmodule

bind fifo_drop_sample_rate_converter fdsrc_chk u_fdsrc_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_byte         (out_if.out_byte),
  .underrun         (out_if.underrun),
  .overflow_dropped (out_if.overflow_dropped),
  .fill_level       (out_if.fill_level)
);
